### rtl/tcpopt_pkg.sv
// Shared types, codes and helpers for the TCP options parser.
`timescale 1ns / 1ps

package tcpopt_pkg;

   // Width of the running area byte count
   localparam int AreaWidth = 6;

   // Depth of the command queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   // Option kind bytes on the wire
   localparam logic [7:0] KIND_END    = 8'd0;
   localparam logic [7:0] KIND_NOP    = 8'd1;
   localparam logic [7:0] KIND_MSS    = 8'd2;
   localparam logic [7:0] KIND_WSCALE = 8'd3;
   localparam logic [7:0] KIND_SACKOK = 8'd4;
   localparam logic [7:0] KIND_SACK   = 8'd5;
   localparam logic [7:0] KIND_TSTAMP = 8'd8;

   // Option currently open in the walker
   localparam logic [2:0] OPEN_NONE   = 3'd0;
   localparam logic [2:0] OPEN_MSS    = 3'd1;
   localparam logic [2:0] OPEN_WSCALE = 3'd2;
   localparam logic [2:0] OPEN_SACKOK = 3'd3;
   localparam logic [2:0] OPEN_TSTAMP = 3'd4;

   // Result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SACK    = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_TRUNC   = 3'd3;
   localparam logic [2:0] ST_LONG    = 3'd4;

   // Field update commands from front to back
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_MSS   = 3'd1;
   localparam logic [2:0] OP_SCALE = 3'd2;
   localparam logic [2:0] OP_TSV   = 3'd3;
   localparam logic [2:0] OP_TSE   = 3'd4;
   localparam logic [2:0] OP_SACK  = 3'd5;

   // Byte lanes that open a multi-byte field (and clear the rest of it)
   localparam logic [1:0] LANE_MSS_TOP = 2'd1;
   localparam logic [1:0] LANE_TS_TOP  = 2'd3;

   // One classified byte traveling through the queue
   typedef struct packed {
      logic [2:0]           op;
      logic [1:0]           lane;
      logic [7:0]           data;
      logic                 last;
      logic [AreaWidth-1:0] area_length;
      logic [2:0]           status;
   } cmd_type;

   // Total size in bytes of an open option
   function automatic logic [3:0] open_size(input logic [2:0] kind);
      logic [3:0] size;
      unique case (kind)
         OPEN_MSS:    size = 4'd4;
         OPEN_WSCALE: size = 4'd3;
         OPEN_SACKOK: size = 4'd2;
         OPEN_TSTAMP: size = 4'd10;
         default:     size = 4'd1;
      endcase
      return size;
   endfunction

endpackage

### rtl/tcpopt_if.sv
// Valid/ready channel interfaces for option bytes and parse results.
`timescale 1ns / 1ps

interface tcpopt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opt_byte;
   logic       last_byte;

   modport source (output valid, output opt_byte, output last_byte, input ready);
   modport sink   (input valid, input opt_byte, input last_byte, output ready);
endinterface

interface tcpopt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_seg_size;
   logic [7:0]  scale_shift;
   logic [31:0] ts_value;
   logic [31:0] ts_echo;
   logic        sack_ok;
   logic [5:0]  area_length;
   logic [2:0]  status;

   modport source (output valid, output max_seg_size, output scale_shift,
                   output ts_value, output ts_echo, output sack_ok,
                   output area_length, output status, input ready);
   modport sink   (input valid, input max_seg_size, input scale_shift,
                   input ts_value, input ts_echo, input sack_ok,
                   input area_length, input status, output ready);
endinterface

### rtl/tcpopt_front.sv
// Front end: walks option boundaries and classifies each byte into a command.
`timescale 1ns / 1ps

module tcpopt_front #(
   parameter int MAX_AREA_BYTES = 40
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [7:0]         opt_byte,
   input  logic               last_byte,
   output tcpopt_pkg::cmd_type cmd
);

   localparam logic [tcpopt_pkg::AreaWidth-1:0] MaxCount =
      tcpopt_pkg::AreaWidth'(MAX_AREA_BYTES);

   logic [tcpopt_pkg::AreaWidth-1:0] count_ff, count_in;
   logic [2:0] kind_ff, kind_in;
   logic [3:0] pos_ff, pos_in;
   logic [2:0] status_ff, status_in;
   logic       stop_ff, stop_in;

   // Per-byte walk of the option list
   always_comb begin
      logic [3:0] pos_next;
      logic [2:0] final_status;
      count_in  = count_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      stop_in   = stop_ff;
      pos_next  = pos_ff + 4'd1;
      cmd.op    = tcpopt_pkg::OP_NONE;
      cmd.lane  = 2'd0;
      cmd.data  = opt_byte;
      cmd.last  = last_byte;

      if (count_ff >= MaxCount) begin
         // area overrun: byte not parsed
         count_in = MaxCount;
         if (status_ff == tcpopt_pkg::ST_OK) status_in = tcpopt_pkg::ST_LONG;
         stop_in = 1'b1;
      end else begin
         count_in = count_ff + 1'b1;
         if (!stop_ff) begin
            if (kind_ff == tcpopt_pkg::OPEN_NONE) begin
               // kind byte opens a new option
               pos_in = 4'd1;
               unique case (opt_byte)
                  tcpopt_pkg::KIND_END: begin
                     stop_in = 1'b1;
                     pos_in  = pos_ff;
                  end
                  tcpopt_pkg::KIND_NOP:    pos_in  = pos_ff;
                  tcpopt_pkg::KIND_MSS:    kind_in = tcpopt_pkg::OPEN_MSS;
                  tcpopt_pkg::KIND_WSCALE: kind_in = tcpopt_pkg::OPEN_WSCALE;
                  tcpopt_pkg::KIND_SACKOK: kind_in = tcpopt_pkg::OPEN_SACKOK;
                  tcpopt_pkg::KIND_TSTAMP: kind_in = tcpopt_pkg::OPEN_TSTAMP;
                  tcpopt_pkg::KIND_SACK: begin
                     if (status_ff == tcpopt_pkg::ST_OK) status_in = tcpopt_pkg::ST_SACK;
                     stop_in = 1'b1;
                     pos_in  = pos_ff;
                  end
                  default: begin
                     if (status_ff == tcpopt_pkg::ST_OK) status_in = tcpopt_pkg::ST_UNKNOWN;
                     stop_in = 1'b1;
                     pos_in  = pos_ff;
                  end
               endcase
            end else begin
               // body byte of the open option
               unique case (kind_ff)
                  tcpopt_pkg::OPEN_MSS: begin
                     if (pos_ff == 4'd2 || pos_ff == 4'd3) begin
                        cmd.op   = tcpopt_pkg::OP_MSS;
                        cmd.lane = (pos_ff == 4'd2) ? tcpopt_pkg::LANE_MSS_TOP : 2'd0;
                     end
                  end
                  tcpopt_pkg::OPEN_WSCALE: begin
                     if (pos_ff == 4'd2) cmd.op = tcpopt_pkg::OP_SCALE;
                  end
                  tcpopt_pkg::OPEN_TSTAMP: begin
                     if (pos_ff >= 4'd2 && pos_ff <= 4'd5) begin
                        cmd.op   = tcpopt_pkg::OP_TSV;
                        cmd.lane = 2'(4'd5 - pos_ff);
                     end else if (pos_ff >= 4'd6 && pos_ff <= 4'd9) begin
                        cmd.op   = tcpopt_pkg::OP_TSE;
                        cmd.lane = 2'(4'd9 - pos_ff);
                     end
                  end
                  default: ;
               endcase
               if (pos_next >= tcpopt_pkg::open_size(kind_ff)) begin
                  if (kind_ff == tcpopt_pkg::OPEN_SACKOK) cmd.op = tcpopt_pkg::OP_SACK;
                  kind_in = tcpopt_pkg::OPEN_NONE;
                  pos_in  = 4'd0;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
      end

      // close of area: flag an option left open
      final_status = status_in;
      if (!stop_in && kind_in != tcpopt_pkg::OPEN_NONE &&
          status_in == tcpopt_pkg::ST_OK) begin
         final_status = tcpopt_pkg::ST_TRUNC;
      end
      cmd.area_length = count_in;
      cmd.status      = final_status;
   end

   // Walker state, cleared at the end of each area
   always_ff @(posedge clock) begin
      if (reset || (push && last_byte)) begin
         count_ff  <= '0;
         kind_ff   <= tcpopt_pkg::OPEN_NONE;
         pos_ff    <= 4'd0;
         status_ff <= tcpopt_pkg::ST_OK;
         stop_ff   <= 1'b0;
      end else if (push) begin
         count_ff  <= count_in;
         kind_ff   <= kind_in;
         pos_ff    <= pos_in;
         status_ff <= status_in;
         stop_ff   <= stop_in;
      end
   end

endmodule

### rtl/tcpopt_queue.sv
// Small command queue decoupling the byte walker from the field assembler.
`timescale 1ns / 1ps

module tcpopt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcpopt_pkg::cmd_type push_word,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output tcpopt_pkg::cmd_type pop_word
);

   tcpopt_pkg::cmd_type entry_ff [tcpopt_pkg::QueueDepth];
   logic [tcpopt_pkg::QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tcpopt_pkg::QueuePtrWidth:0]   count_ff, count_in;

   assign full      = (count_ff == (tcpopt_pkg::QueuePtrWidth+1)'(tcpopt_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign pop_word  = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_word;
   end

endmodule

### rtl/tcpopt_back.sv
// Back end: assembles field values from commands and holds the result register.
`timescale 1ns / 1ps

module tcpopt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  tcpopt_pkg::cmd_type cmd,
   output logic                cmd_take,
   tcpopt_rsp_if.source        rsp
);

   logic [15:0] mss_ff, mss_in;
   logic [7:0]  scale_ff, scale_in;
   logic [31:0] tsv_ff, tsv_in;
   logic [31:0] tse_ff, tse_in;
   logic        sack_ff, sack_in;

   logic        rsp_valid_ff;
   logic [15:0] out_mss_ff;
   logic [7:0]  out_scale_ff;
   logic [31:0] out_tsv_ff;
   logic [31:0] out_tse_ff;
   logic        out_sack_ff;
   logic [5:0]  out_len_ff;
   logic [2:0]  out_status_ff;

   // a closing word needs the result register free
   assign cmd_take = cmd_valid && (!cmd.last || !rsp_valid_ff || rsp.ready);

   // field updates
   always_comb begin
      mss_in   = mss_ff;
      scale_in = scale_ff;
      tsv_in   = tsv_ff;
      tse_in   = tse_ff;
      sack_in  = sack_ff;
      unique case (cmd.op)
         tcpopt_pkg::OP_MSS: begin
            if (cmd.lane == tcpopt_pkg::LANE_MSS_TOP) mss_in = {cmd.data, 8'h00};
            else mss_in[7:0] = cmd.data;
         end
         tcpopt_pkg::OP_SCALE: scale_in = cmd.data;
         tcpopt_pkg::OP_TSV: begin
            if (cmd.lane == tcpopt_pkg::LANE_TS_TOP) tsv_in = {cmd.data, 24'h0};
            else tsv_in[8*cmd.lane +: 8] = cmd.data;
         end
         tcpopt_pkg::OP_TSE: begin
            if (cmd.lane == tcpopt_pkg::LANE_TS_TOP) tse_in = {cmd.data, 24'h0};
            else tse_in[8*cmd.lane +: 8] = cmd.data;
         end
         tcpopt_pkg::OP_SACK: sack_in = 1'b1;
         default: ;
      endcase
   end

   // accumulators, cleared once an area's result is captured
   always_ff @(posedge clock) begin
      if (reset || (cmd_take && cmd.last)) begin
         mss_ff   <= '0;
         scale_ff <= '0;
         tsv_ff   <= '0;
         tse_ff   <= '0;
         sack_ff  <= 1'b0;
      end else if (cmd_take) begin
         mss_ff   <= mss_in;
         scale_ff <= scale_in;
         tsv_ff   <= tsv_in;
         tse_ff   <= tse_in;
         sack_ff  <= sack_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_take && cmd.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take && cmd.last) begin
         out_mss_ff    <= mss_in;
         out_scale_ff  <= scale_in;
         out_tsv_ff    <= tsv_in;
         out_tse_ff    <= tse_in;
         out_sack_ff   <= sack_in;
         out_len_ff    <= cmd.area_length;
         out_status_ff <= cmd.status;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.max_seg_size = out_mss_ff;
   assign rsp.scale_shift  = out_scale_ff;
   assign rsp.ts_value     = out_tsv_ff;
   assign rsp.ts_echo      = out_tse_ff;
   assign rsp.sack_ok      = out_sack_ff;
   assign rsp.area_length  = out_len_ff;
   assign rsp.status       = out_status_ff;

endmodule

### rtl/tcp_option_parser_top.sv
// Top level of the TCP options parser: front walker, command queue, back assembler.
//
//   channel    dir  words                         handshake
//   req_chan   in   opt_byte, last_byte           valid/ready
//   rsp_chan   out  mss, scale, ts, echo, sack,   valid/ready
//                   area_length, status
//
// One option byte is taken per cycle while the command queue is not full; a
// result is registered when the back end takes its closing byte.
// The four-entry command queue sets how far the input runs ahead of a
// stalled result port; req ready drops only when it is full.
// Synchronous active-high reset empties the queue and clears all parse state.
`timescale 1ns / 1ps

module tcp_option_parser_top #(
   parameter int MAX_AREA_BYTES = 40
) (
   input  logic         clock,
   input  logic         reset,
   tcpopt_req_if.sink   req_chan,
   tcpopt_rsp_if.source rsp_chan
);

   logic                push, queue_full, queue_not_empty, cmd_take;
   tcpopt_pkg::cmd_type front_cmd, back_cmd;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   tcpopt_front #(
      .MAX_AREA_BYTES(MAX_AREA_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .opt_byte  (req_chan.opt_byte),
      .last_byte (req_chan.last_byte),
      .cmd       (front_cmd)
   );

   tcpopt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (front_cmd),
      .full      (queue_full),
      .pop       (cmd_take),
      .not_empty (queue_not_empty),
      .pop_word  (back_cmd)
   );

   tcpopt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (back_cmd),
      .cmd_take  (cmd_take),
      .rsp       (rsp_chan)
   );

endmodule

### rtl/tcpopt_checker.sv
// Port-level checks on the TCP options parser, bound to the top level.
`timescale 1ns / 1ps

module tcpopt_checker #(
   parameter int MAX_AREA_BYTES = 40
) (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_area_length,
   input logic [2:0] rsp_status
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_area_length) && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   // reset leaves the queue empty and no result pending
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("reset did not clear queue or result");

   // area length stays within the configured bound
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_area_length != 6'd0 && rsp_area_length <= 6'(MAX_AREA_BYTES))
      else $error("area length out of range");

   // overrun status only on a saturated area
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tcpopt_pkg::ST_LONG |-> rsp_area_length == 6'(MAX_AREA_BYTES))
      else $error("overrun status without full area");

   // status stays among the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= tcpopt_pkg::ST_LONG)
      else $error("undefined status code");

endmodule

bind tcp_option_parser_top tcpopt_checker #(
   .MAX_AREA_BYTES(MAX_AREA_BYTES)
) u_tcpopt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_area_length (rsp_chan.area_length),
   .rsp_status      (rsp_chan.status)
);

### sim/tb.sv
// Self-checking testbench for the TCP options parser: directed rows, then random option areas.
`timescale 1ns / 1ps

module tb;

   localparam int AreaMax     = 40;
   localparam int ItemTarget  = 1650;
   localparam int IdleLimit   = 4000;
   localparam int DrainCycles = 8;
   localparam int ReportMax   = 10;

   // One parse result, in port order
   typedef struct packed {
      logic [15:0] mss;
      logic [7:0]  scale;
      logic [31:0] tsval;
      logic [31:0] tsecr;
      logic        sack;
      logic [5:0]  length;
      logic [2:0]  status;
   } parse_result_type;

   // Running state of the option walker
   typedef struct packed {
      logic [5:0]  count;
      logic [2:0]  kind;
      logic [3:0]  pos;
      logic [15:0] mss;
      logic [7:0]  scale;
      logic [31:0] tsval;
      logic [31:0] tsecr;
      logic        sack;
      logic [2:0]  status;
      logic        stopped;
   } walker_state_type;

   // Directed word; fixed_want marks a row whose result is typed in
   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic             fixed_want;
      parse_result_type want;
   } directed_row_type;

   localparam parse_result_type NoWant = '0;

   localparam directed_row_type DirectedRows [24] = '{
      // single-byte areas: END, SACK block, unknown kind
      '{tcpopt_pkg::KIND_END,  1'b1, 1'b1,
        '{16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 6'd1, tcpopt_pkg::ST_OK}},
      '{tcpopt_pkg::KIND_SACK, 1'b1, 1'b1,
        '{16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 6'd1, tcpopt_pkg::ST_SACK}},
      '{8'hFF,                 1'b1, 1'b1,
        '{16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 6'd1, tcpopt_pkg::ST_UNKNOWN}},
      // MSS at its largest value
      '{tcpopt_pkg::KIND_MSS,  1'b0, 1'b0, NoWant},
      '{8'd4,                  1'b0, 1'b0, NoWant},
      '{8'hFF,                 1'b0, 1'b0, NoWant},
      '{8'hFF,                 1'b1, 1'b1,
        '{16'hFFFF, 8'h0, 32'h0, 32'h0, 1'b0, 6'd4, tcpopt_pkg::ST_OK}},
      // window scale, NOP, SACK-permitted
      '{tcpopt_pkg::KIND_WSCALE, 1'b0, 1'b0, NoWant},
      '{8'd3,                    1'b0, 1'b0, NoWant},
      '{8'd14,                   1'b0, 1'b0, NoWant},
      '{tcpopt_pkg::KIND_NOP,    1'b0, 1'b0, NoWant},
      '{tcpopt_pkg::KIND_SACKOK, 1'b0, 1'b0, NoWant},
      '{8'd2,                    1'b1, 1'b0, NoWant},
      // full timestamp
      '{tcpopt_pkg::KIND_TSTAMP, 1'b0, 1'b0, NoWant},
      '{8'd10,                   1'b0, 1'b0, NoWant},
      '{8'h00,                   1'b0, 1'b0, NoWant},
      '{8'hFF,                   1'b0, 1'b0, NoWant},
      '{8'h80,                   1'b0, 1'b0, NoWant},
      '{8'h01,                   1'b0, 1'b0, NoWant},
      '{8'hFF,                   1'b0, 1'b0, NoWant},
      '{8'h00,                   1'b0, 1'b0, NoWant},
      '{8'h7F,                   1'b0, 1'b0, NoWant},
      '{8'hFE,                   1'b1, 1'b0, NoWant},
      // MSS cut off after its kind byte
      '{tcpopt_pkg::KIND_MSS,    1'b1, 1'b1,
        '{16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 6'd1, tcpopt_pkg::ST_TRUNC}}
   };

   logic clock = 1'b0;
   logic reset;

   tcpopt_req_if req_chan ();
   tcpopt_rsp_if rsp_chan ();

   tcp_option_parser_top #(
      .MAX_AREA_BYTES(AreaMax)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   walker_state_type walker;
   parse_result_type pending_results[$];
   logic [7:0]       area_bytes[$];
   int               mismatches;
   int               items_sent;
   int               idle_pct;
   int               stall_pct;
   int               quiet_cycles;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // First error code sticks; any error stops the walk
   function automatic void flag_error(input logic [2:0] code);
      if (walker.status == tcpopt_pkg::ST_OK) walker.status = code;
      walker.stopped = 1'b1;
   endfunction

   // Advance the walker by one word; returns 1 with the result on the last byte
   function automatic bit walk_option_byte(input logic [7:0] data, input logic last,
                                           output parse_result_type res);
      int pos;
      int span;
      res = '0;
      if (walker.count >= AreaMax) begin
         walker.count = 6'(AreaMax);
         flag_error(tcpopt_pkg::ST_LONG);
      end else begin
         walker.count++;
         if (!walker.stopped && walker.kind == tcpopt_pkg::OPEN_NONE) begin
            // kind byte opens an option
            case (data)
               tcpopt_pkg::KIND_END:    walker.stopped = 1'b1;
               tcpopt_pkg::KIND_NOP:    ;
               tcpopt_pkg::KIND_MSS:    walker.kind = tcpopt_pkg::OPEN_MSS;
               tcpopt_pkg::KIND_WSCALE: walker.kind = tcpopt_pkg::OPEN_WSCALE;
               tcpopt_pkg::KIND_SACKOK: walker.kind = tcpopt_pkg::OPEN_SACKOK;
               tcpopt_pkg::KIND_TSTAMP: walker.kind = tcpopt_pkg::OPEN_TSTAMP;
               tcpopt_pkg::KIND_SACK:   flag_error(tcpopt_pkg::ST_SACK);
               default:                 flag_error(tcpopt_pkg::ST_UNKNOWN);
            endcase
            if (walker.kind != tcpopt_pkg::OPEN_NONE) walker.pos = 4'd1;
         end else if (!walker.stopped) begin
            // body byte of the open option; length byte is skipped
            pos = walker.pos;
            case (walker.kind)
               tcpopt_pkg::OPEN_MSS: begin
                  if (pos == 2) walker.mss = {data, 8'h00};
                  else if (pos == 3) walker.mss[7:0] = data;
               end
               tcpopt_pkg::OPEN_WSCALE: begin
                  if (pos == 2) walker.scale = data;
               end
               tcpopt_pkg::OPEN_TSTAMP: begin
                  if (pos == 2) walker.tsval = {data, 24'h0};
                  else if (pos >= 3 && pos <= 5) walker.tsval[8*(5-pos) +: 8] = data;
                  else if (pos == 6) walker.tsecr = {data, 24'h0};
                  else if (pos >= 7 && pos <= 9) walker.tsecr[8*(9-pos) +: 8] = data;
               end
               default: ;
            endcase
            case (walker.kind)
               tcpopt_pkg::OPEN_MSS:    span = 4;
               tcpopt_pkg::OPEN_WSCALE: span = 3;
               tcpopt_pkg::OPEN_SACKOK: span = 2;
               tcpopt_pkg::OPEN_TSTAMP: span = 10;
               default:                 span = 1;
            endcase
            pos++;
            if (pos >= span) begin
               if (walker.kind == tcpopt_pkg::OPEN_SACKOK) walker.sack = 1'b1;
               walker.kind = tcpopt_pkg::OPEN_NONE;
               pos = 0;
            end
            walker.pos = 4'(pos);
         end
      end
      if (!last) return 1'b0;
      if (!walker.stopped && walker.kind != tcpopt_pkg::OPEN_NONE)
         flag_error(tcpopt_pkg::ST_TRUNC);
      res = '{walker.mss, walker.scale, walker.tsval, walker.tsecr, walker.sack,
              walker.count, walker.status};
      walker = '0;
      return 1'b1;
   endfunction

   // Offer one word, wait for acceptance, then queue the expected result if it closes an area
   task automatic send_word(input logic [7:0] data, input logic last,
                            input logic fixed_want, input parse_result_type want);
      parse_result_type predicted;
      bit               has_result;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opt_byte  <= data;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      has_result = walk_option_byte(data, last, predicted);
      if (has_result) pending_results.push_back(fixed_want ? want : predicted);
   endtask

   // Random options area: mostly well-formed options, some errors, some overlong
   task automatic build_area();
      int target;
      int pick;
      int span;
      int kind_val;
      area_bytes.delete();
      if ($urandom_range(0, 99) < 8) target = $urandom_range(AreaMax + 1, AreaMax + 8);
      else target = $urandom_range(1, AreaMax);
      while (area_bytes.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            // END followed by garbage padding
            area_bytes.push_back(tcpopt_pkg::KIND_END);
            repeat ($urandom_range(0, 8)) area_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 7) begin
            area_bytes.push_back(tcpopt_pkg::KIND_SACK);
            area_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 10) begin
            do kind_val = $urandom_range(6, 255);
            while (kind_val == tcpopt_pkg::KIND_TSTAMP);
            area_bytes.push_back(8'(kind_val));
         end else if (pick < 30) begin
            area_bytes.push_back(tcpopt_pkg::KIND_NOP);
         end else begin
            pick = $urandom_range(0, 3);
            case (pick)
               0: begin area_bytes.push_back(tcpopt_pkg::KIND_MSS);    span = 4;  end
               1: begin area_bytes.push_back(tcpopt_pkg::KIND_WSCALE); span = 3;  end
               2: begin area_bytes.push_back(tcpopt_pkg::KIND_SACKOK); span = 2;  end
               default: begin area_bytes.push_back(tcpopt_pkg::KIND_TSTAMP); span = 10; end
            endcase
            // length byte is usually right, but the block never checks it
            if ($urandom_range(0, 99) < 90) area_bytes.push_back(8'(span));
            else area_bytes.push_back(8'($urandom_range(0, 255)));
            repeat (span - 2) area_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      // trimming to size may cut the final option short
      while (area_bytes.size() > target) void'(area_bytes.pop_back());
   endtask

   // Receiver: random stall according to the current phase
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      parse_result_type got;
      parse_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.max_seg_size, rsp_chan.scale_shift, rsp_chan.ts_value,
                 rsp_chan.ts_echo, rsp_chan.sack_ok, rsp_chan.area_length, rsp_chan.status};
         if (pending_results.size() == 0) begin
            if (mismatches < ReportMax) begin
               $display("%0t: unexpected result", $realtime);
               $display("  got mss=%h scale=%h tsv=%h tse=%h sack=%b len=%0d st=%0d",
                        got.mss, got.scale, got.tsval, got.tsecr, got.sack,
                        got.length, got.status);
            end
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.mss !== want.mss || got.scale !== want.scale ||
                got.tsval !== want.tsval || got.tsecr !== want.tsecr ||
                got.sack !== want.sack || got.length !== want.length ||
                got.status !== want.status) begin
               if (mismatches < ReportMax) begin
                  $display("%0t: mismatch", $realtime);
                  $display("  exp mss=%h scale=%h tsv=%h tse=%h sack=%b len=%0d st=%0d",
                           want.mss, want.scale, want.tsval, want.tsecr, want.sack,
                           want.length, want.status);
                  $display("  got mss=%h scale=%h tsv=%h tse=%h sack=%b len=%0d st=%0d",
                           got.mss, got.scale, got.tsval, got.tsecr, got.sack,
                           got.length, got.status);
               end
               mismatches++;
            end
         end
      end
   end

   // Watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= IdleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Main sequence
   initial begin
      walker       = '0;
      mismatches   = 0;
      items_sent   = 0;
      idle_pct     = 0;
      stall_pct    = 0;
      quiet_cycles = 0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.opt_byte  <= 8'h00;
      req_chan.last_byte <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (DirectedRows[i])
         send_word(DirectedRows[i].data, DirectedRows[i].last,
                   DirectedRows[i].fixed_want, DirectedRows[i].want);

      // random areas; idling phases change between areas
      while (items_sent < ItemTarget) begin
         case (items_sent * 4 / ItemTarget)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 75; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase
         build_area();
         foreach (area_bytes[i])
            send_word(area_bytes[i], i == area_bytes.size() - 1, 1'b0, NoWant);
      end
      req_chan.valid <= 1'b0;

      // drain
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
rtl/tcpopt_pkg.sv
rtl/tcpopt_if.sv
rtl/tcpopt_front.sv
rtl/tcpopt_queue.sv
rtl/tcpopt_back.sv
rtl/tcp_option_parser_top.sv
rtl/tcpopt_checker.sv
sim/tb.sv
